// File: sv/bms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_pkg
// Shared types, constants and arithmetic helpers for the battery measurement
// sequencer.
// ----------------------------------------------------------------------------
package bms_pkg;

    localparam int N_SAMPLES  = 5;
    localparam int TIME_W     = 32;
    localparam int REG_W      = 16;
    localparam int SAMPLE_W   = 12;
    localparam int SUM_W      = 15;
    localparam int COUNT_W    = 3;
    localparam int VOLT_W     = 13;
    localparam int PCT_W      = 7;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [REG_W-1:0] PERIOD_RESET = 16'd1000;
    localparam logic [REG_W-1:0] SETTLE_RESET = 16'd100;

    localparam logic REG_PERIOD = 1'b0;
    localparam logic REG_SETTLE = 1'b1;

    localparam logic ACTION_TICK   = 1'b0;
    localparam logic ACTION_SAMPLE = 1'b1;

    localparam logic [COUNT_W-1:0] N_SAMPLES_C = COUNT_W'(N_SAMPLES);

    // Reciprocal multiply: exact quotient for every sum below 2**SUM_W
    localparam int DIV_SHIFT = SUM_W + COUNT_W;
    localparam int RECIP     = ((2 ** DIV_SHIFT) + N_SAMPLES - 1) / N_SAMPLES;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;

    localparam logic [VOLT_W-1:0] MV_FULL  = 13'd4200;
    localparam logic [VOLT_W-1:0] MV_EMPTY = 13'd3400;
    localparam logic [PCT_W-1:0]  PCT_FULL = 7'd100;

    typedef struct packed {
        logic [REG_W-1:0] period_ms;
        logic [REG_W-1:0] settle_ms;
    } bms_cfg_t;

    function automatic logic [PCT_W-1:0] charge_from_mv(input logic [VOLT_W-1:0] mv);
        logic [VOLT_W-1:0] diff;
        logic [PCT_W-1:0]  pct;
        diff = mv - MV_EMPTY;
        if (mv > MV_FULL)
        begin
            pct = PCT_FULL;
        end
        else if (mv < MV_EMPTY)
        begin
            pct = '0;
        end
        else
        begin
            pct = diff[PCT_W+2:3];
        end
        return pct;
    endfunction

endpackage

// File: sv/bms_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_in_if / bms_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface bms_in_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [bms_pkg::TIME_W-1:0]    now_ms;
    logic [bms_pkg::SAMPLE_W-1:0]  sample_mv;

    modport source (output valid, action, now_ms, sample_mv, input ready);
    modport sink   (input valid, action, now_ms, sample_mv, output ready);
endinterface

interface bms_out_if;
    logic                        valid;
    logic                        ready;
    logic                        switch_on;
    logic                        request_sample;
    logic                        measurement_done;
    logic [bms_pkg::VOLT_W-1:0]  voltage_mv;
    logic [bms_pkg::PCT_W-1:0]   percent;

    modport source (output valid, switch_on, request_sample, measurement_done,
                    voltage_mv, percent, input ready);
    modport sink   (input valid, switch_on, request_sample, measurement_done,
                    voltage_mv, percent, output ready);
endinterface

// File: sv/bms_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_cfg
// APB register file holding the measurement period and settle time.
// ----------------------------------------------------------------------------
module bms_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bms_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bms_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bms_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output bms_pkg::bms_cfg_t                cfg
);

    logic [bms_pkg::REG_W-1:0] period_reg;
    logic [bms_pkg::REG_W-1:0] settle_reg;
    logic                      wr_en;
    logic                      reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= bms_pkg::PERIOD_RESET;
            settle_reg <= bms_pkg::SETTLE_RESET;
        end
        else if (wr_en)
        begin
            if (reg_sel == bms_pkg::REG_PERIOD)
            begin
                period_reg <= pwdata[bms_pkg::REG_W-1:0];
            end
            else
            begin
                settle_reg <= pwdata[bms_pkg::REG_W-1:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_sel == bms_pkg::REG_PERIOD)
        begin
            prdata[bms_pkg::REG_W-1:0] = period_reg;
        end
        else
        begin
            prdata[bms_pkg::REG_W-1:0] = settle_reg;
        end
    end

    assign cfg.period_ms = period_reg;
    assign cfg.settle_ms = settle_reg;

endmodule

// File: sv/bms_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_seq
// Input register, measurement state and result register. Each registered
// item updates the state and produces one result in a single pass.
// ----------------------------------------------------------------------------
module bms_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  bms_pkg::bms_cfg_t  cfg,
    bms_in_if.sink             item,
    bms_out_if.source          result
);

    // Input stage
    logic                           in_valid_reg;
    logic                           action_reg;
    logic [bms_pkg::TIME_W-1:0]     now_reg;
    logic [bms_pkg::SAMPLE_W-1:0]   smp_reg;

    // Measurement state
    logic [bms_pkg::TIME_W-1:0]     last_start_reg, last_start_next;
    logic                           switch_reg, switch_next;
    logic                           sampling_reg, sampling_next;
    logic [bms_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic [bms_pkg::SUM_W-1:0]      sum_reg, sum_next;
    logic [bms_pkg::VOLT_W-1:0]     volt_reg, volt_next;
    logic [bms_pkg::PCT_W-1:0]      pct_reg, pct_next;

    // Result stage
    logic                           out_valid_reg;
    logic                           req_reg, req_next;
    logic                           done_reg, done_next;

    logic                           advance;
    logic                           fire;
    logic                           load;
    logic [bms_pkg::TIME_W-1:0]     elapsed;
    logic [bms_pkg::REG_W:0]        window_end;
    logic [bms_pkg::SUM_W-1:0]      sum_acc;
    logic [bms_pkg::COUNT_W-1:0]    count_inc;
    logic [bms_pkg::PROD_W-1:0]     quot_prod;
    logic [bms_pkg::SUM_W-1:0]      avg;
    logic [bms_pkg::VOLT_W-1:0]     volt_calc;

    assign advance    = !out_valid_reg || result.ready;
    assign fire       = in_valid_reg && advance;
    assign item.ready = !in_valid_reg || advance;
    assign load       = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            action_reg <= item.action;
            now_reg    <= item.now_ms;
            smp_reg    <= item.sample_mv;
        end
    end

    assign elapsed    = now_reg - last_start_reg;
    assign window_end = {1'b0, cfg.period_ms} + {1'b0, cfg.settle_ms};
    assign sum_acc    = sum_reg + bms_pkg::SUM_W'(smp_reg);
    assign count_inc  = count_reg + 1'b1;
    assign quot_prod  = bms_pkg::PROD_W'(sum_acc)
                      * bms_pkg::PROD_W'(bms_pkg::RECIP);
    assign avg        = quot_prod[bms_pkg::DIV_SHIFT +: bms_pkg::SUM_W];
    assign volt_calc  = {avg[bms_pkg::VOLT_W-2:0], 1'b0};

    always_comb
    begin
        last_start_next = last_start_reg;
        switch_next     = switch_reg;
        sampling_next   = sampling_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        volt_next       = volt_reg;
        pct_next        = pct_reg;
        req_next        = 1'b0;
        done_next       = 1'b0;
        if (action_reg == bms_pkg::ACTION_TICK)
        begin
            if (!sampling_reg && elapsed >= bms_pkg::TIME_W'(cfg.period_ms))
            begin
                if (elapsed < bms_pkg::TIME_W'(window_end))
                begin
                    switch_next = 1'b1;
                end
                else
                begin
                    sampling_next   = 1'b1;
                    count_next      = '0;
                    sum_next        = '0;
                    last_start_next = now_reg;
                    req_next        = 1'b1;
                end
            end
        end
        else if (sampling_reg)
        begin
            sum_next   = sum_acc;
            count_next = count_inc;
            if (count_inc >= bms_pkg::N_SAMPLES_C)
            begin
                volt_next     = volt_calc;
                pct_next      = bms_pkg::charge_from_mv(volt_calc);
                switch_next   = 1'b0;
                sampling_next = 1'b0;
                count_next    = '0;
                done_next     = 1'b1;
            end
            else
            begin
                req_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_start_reg <= '0;
            switch_reg     <= 1'b0;
            sampling_reg   <= 1'b0;
            count_reg      <= '0;
            sum_reg        <= '0;
            volt_reg       <= '0;
            pct_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                last_start_reg <= last_start_next;
                switch_reg     <= switch_next;
                sampling_reg   <= sampling_next;
                count_reg      <= count_next;
                sum_reg        <= sum_next;
                volt_reg       <= volt_next;
                pct_reg        <= pct_next;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            req_reg  <= req_next;
            done_reg <= done_next;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.switch_on        = switch_reg;
    assign result.request_sample   = req_reg;
    assign result.measurement_done = done_reg;
    assign result.voltage_mv       = volt_reg;
    assign result.percent          = pct_reg;

endmodule

// File: sv/battery_measure_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_measure_sequencer
// Periodic battery check: switch control, sample averaging and charge
// estimate behind valid/ready channels and an APB register port.
// ----------------------------------------------------------------------------
// Takes one tick or sample transaction per clock and returns exactly one
// result transaction for each, after the item has passed first through the
// input register and then the result register. Throughput is one transaction
// per cycle, limited only by result backpressure. The average is a reciprocal
// multiply of the sample sum; voltage and percent hold their last values
// between measurements. Registers: period_ms at byte 0, settle_ms at byte 4.
// ----------------------------------------------------------------------------
module battery_measure_sequencer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bms_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bms_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bms_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    bms_in_if.sink                           item,
    bms_out_if.source                        result
);

    bms_pkg::bms_cfg_t cfg;

    bms_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bms_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (item),
        .result (result)
    );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives tick and sample transactions into battery_measure_sequencer and
// compares every result transaction against an in-bench prediction of the
// switch, sample request, completion flag, voltage and charge percentage.
// A directed table covers reset, extremes, stray and ignored items and time
// wrap; random measurement sequences follow under several register settings
// and idle patterns on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import bms_pkg::*;

    localparam int          DIR_ROWS       = 25;
    localparam int          RAND_PER_PHASE = 105;
    localparam int          PHASES         = 6;
    localparam int          LIMIT_NS       = 2_000_000;
    localparam logic [APB_ADDR_W-1:0] ADDR_PERIOD = {REG_PERIOD, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_SETTLE = {REG_SETTLE, 2'b00};

    typedef struct packed {
        logic              switch_on;
        logic              request_sample;
        logic              measurement_done;
        logic [VOLT_W-1:0] voltage_mv;
        logic [PCT_W-1:0]  percent;
    } reading_t;

    typedef struct packed {
        logic                action;
        logic [TIME_W-1:0]   now_ms;
        logic [SAMPLE_W-1:0] sample_mv;
        logic                typed;
        reading_t            want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bms_in_if  item_if ();
    bms_out_if res_if ();

    battery_measure_sequencer u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item    (item_if),
        .result  (res_if)
    );

    // predicted block state
    logic [TIME_W-1:0]  m_last_start;
    logic               m_switch;
    logic               m_sampling;
    logic [COUNT_W-1:0] m_count;
    logic [SUM_W-1:0]   m_sum;
    logic [VOLT_W-1:0]  m_volt;
    logic [PCT_W-1:0]   m_pct;
    logic [REG_W-1:0]   cfg_period;
    logic [REG_W-1:0]   cfg_settle;

    reading_t pending_readings[$];
    int       mismatches;
    int       send_idle_pct;
    int       stall_pct;

    stim_row_t dir_rows [DIR_ROWS] = '{
        {ACTION_TICK,   32'd0,          12'd0,    1'b1, 1'b0, 1'b0, 1'b0, 13'd0,    7'd0},
        {ACTION_SAMPLE, 32'hFFFF_FFFF,  12'd4095, 1'b1, 1'b0, 1'b0, 1'b0, 13'd0,    7'd0},
        {ACTION_TICK,   32'd999,        12'd4095, 1'b1, 1'b0, 1'b0, 1'b0, 13'd0,    7'd0},
        {ACTION_TICK,   32'd1000,       12'd0,    1'b1, 1'b1, 1'b0, 1'b0, 13'd0,    7'd0},
        {ACTION_TICK,   32'd1099,       12'd0,    1'b1, 1'b1, 1'b0, 1'b0, 13'd0,    7'd0},
        {ACTION_TICK,   32'd1100,       12'd0,    1'b1, 1'b1, 1'b1, 1'b0, 13'd0,    7'd0},
        {ACTION_TICK,   32'h8000_0000,  12'd0,    1'b1, 1'b1, 1'b0, 1'b0, 13'd0,    7'd0},
        {ACTION_SAMPLE, 32'd0,          12'd4095, 1'b1, 1'b1, 1'b1, 1'b0, 13'd0,    7'd0},
        {ACTION_SAMPLE, 32'd0,          12'd4095, 1'b1, 1'b1, 1'b1, 1'b0, 13'd0,    7'd0},
        {ACTION_SAMPLE, 32'd0,          12'd4095, 1'b1, 1'b1, 1'b1, 1'b0, 13'd0,    7'd0},
        {ACTION_SAMPLE, 32'd0,          12'd4095, 1'b1, 1'b1, 1'b1, 1'b0, 13'd0,    7'd0},
        {ACTION_SAMPLE, 32'd0,          12'd4095, 1'b1, 1'b0, 1'b0, 1'b1, 13'd8190, 7'd100},
        {ACTION_TICK,   32'd2200,       12'd0,    1'b1, 1'b0, 1'b1, 1'b0, 13'd8190, 7'd100},
        {ACTION_SAMPLE, 32'hFFFF_FFFF,  12'd0,    1'b1, 1'b0, 1'b1, 1'b0, 13'd8190, 7'd100},
        {ACTION_SAMPLE, 32'hFFFF_FFFF,  12'd0,    1'b1, 1'b0, 1'b1, 1'b0, 13'd8190, 7'd100},
        {ACTION_SAMPLE, 32'hFFFF_FFFF,  12'd0,    1'b1, 1'b0, 1'b1, 1'b0, 13'd8190, 7'd100},
        {ACTION_SAMPLE, 32'hFFFF_FFFF,  12'd0,    1'b1, 1'b0, 1'b1, 1'b0, 13'd8190, 7'd100},
        {ACTION_SAMPLE, 32'hFFFF_FFFF,  12'd0,    1'b1, 1'b0, 1'b0, 1'b1, 13'd0,    7'd0},
        {ACTION_TICK,   32'hFFFF_FFFF,  12'd0,    1'b1, 1'b0, 1'b1, 1'b0, 13'd0,    7'd0},
        {ACTION_SAMPLE, 32'd0,          12'd1699, 1'b0, 23'd0},
        {ACTION_SAMPLE, 32'd0,          12'd1699, 1'b0, 23'd0},
        {ACTION_SAMPLE, 32'd0,          12'd1699, 1'b0, 23'd0},
        {ACTION_SAMPLE, 32'd0,          12'd1699, 1'b0, 23'd0},
        {ACTION_SAMPLE, 32'd0,          12'd1699, 1'b1, 1'b0, 1'b0, 1'b1, 13'd3398, 7'd0},
        {ACTION_TICK,   32'd1099,       12'd0,    1'b1, 1'b0, 1'b1, 1'b0, 13'd3398, 7'd0}
    };

    function automatic reading_t next_reading(input logic act, input logic [TIME_W-1:0] now,
                                              input logic [SAMPLE_W-1:0] smp);
        reading_t          r;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] window_end;
        r = '0;
        if (act == ACTION_TICK)
        begin
            if (!m_sampling)
            begin
                elapsed    = now - m_last_start;
                window_end = 32'(cfg_period) + 32'(cfg_settle);
                if (elapsed >= 32'(cfg_period))
                begin
                    if (elapsed < window_end)
                    begin
                        m_switch = 1'b1;
                    end
                    else
                    begin
                        m_sampling       = 1'b1;
                        m_count          = '0;
                        m_sum            = '0;
                        m_last_start     = now;
                        r.request_sample = 1'b1;
                    end
                end
            end
        end
        else if (m_sampling)
        begin
            m_sum   = m_sum + SUM_W'(smp);
            m_count = m_count + 1'b1;
            if (m_count >= N_SAMPLES_C)
            begin
                m_volt = VOLT_W'((m_sum / N_SAMPLES) * 2);
                if (m_volt > MV_FULL)
                begin
                    m_pct = PCT_FULL;
                end
                else if (m_volt < MV_EMPTY)
                begin
                    m_pct = '0;
                end
                else
                begin
                    m_pct = PCT_W'((m_volt - MV_EMPTY) / 8);
                end
                m_switch           = 1'b0;
                m_sampling         = 1'b0;
                m_count            = '0;
                r.measurement_done = 1'b1;
            end
            else
            begin
                r.request_sample = 1'b1;
            end
        end
        r.switch_on  = m_switch;
        r.voltage_mv = m_volt;
        r.percent    = m_pct;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [VOLT_W-1:0] want,
                               input logic [VOLT_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic send_item(input logic act, input logic [TIME_W-1:0] now,
                             input logic [SAMPLE_W-1:0] smp, input logic typed,
                             input reading_t want);
        reading_t predicted;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            item_if.valid <= 1'b0;
            @(posedge clk);
        end
        item_if.valid     <= 1'b1;
        item_if.action    <= act;
        item_if.now_ms    <= now;
        item_if.sample_mv <= smp;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
        predicted = next_reading(act, now, smp);
        pending_readings.push_back(typed ? want : predicted);
    endtask

    task automatic apb_xfer(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic verify_regs();
        logic [APB_DATA_W-1:0] rd;
        apb_xfer(1'b0, ADDR_PERIOD, '0, rd);
        if (rd[REG_W-1:0] !== cfg_period)
        begin
            $display("%0t: period_ms readback, expected %0d, actual %0d",
                     $time, cfg_period, rd[REG_W-1:0]);
            mismatches++;
        end
        apb_xfer(1'b0, ADDR_SETTLE, '0, rd);
        if (rd[REG_W-1:0] !== cfg_settle)
        begin
            $display("%0t: settle_ms readback, expected %0d, actual %0d",
                     $time, cfg_settle, rd[REG_W-1:0]);
            mismatches++;
        end
    endtask

    task automatic program_regs(input logic [REG_W-1:0] period, input logic [REG_W-1:0] settle);
        logic [APB_DATA_W-1:0] rd;
        item_if.valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        apb_xfer(1'b1, ADDR_PERIOD, APB_DATA_W'(period), rd);
        apb_xfer(1'b1, ADDR_SETTLE, APB_DATA_W'(settle), rd);
        cfg_period = period;
        cfg_settle = settle;
        verify_regs();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            res_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(negedge clk)
    begin
        reading_t seen;
        reading_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            seen = {res_if.switch_on, res_if.request_sample, res_if.measurement_done,
                    res_if.voltage_mv, res_if.percent};
            if (pending_readings.size() == 0)
            begin
                $display("%0t: unexpected result transaction, expected none, actual %h",
                         $time, seen);
                mismatches++;
            end
            else
            begin
                want = pending_readings.pop_front();
                check_field("switch_on", VOLT_W'(want.switch_on), VOLT_W'(seen.switch_on));
                check_field("request_sample", VOLT_W'(want.request_sample),
                            VOLT_W'(seen.request_sample));
                check_field("measurement_done", VOLT_W'(want.measurement_done),
                            VOLT_W'(seen.measurement_done));
                check_field("voltage_mv", want.voltage_mv, seen.voltage_mv);
                check_field("percent", VOLT_W'(want.percent), VOLT_W'(seen.percent));
            end
        end
    end

    initial
    begin
        int unsigned       ph;
        int unsigned       n;
        int unsigned       r;
        int unsigned       span;
        int unsigned       off;
        int                aim;
        int                v;
        logic              act;
        logic [TIME_W-1:0] t;
        logic [SAMPLE_W-1:0] s;
        logic [REG_W-1:0]  np;
        logic [REG_W-1:0]  ns;

        mismatches    = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        aim           = 0;
        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        item_if.valid     <= 1'b0;
        item_if.action    <= ACTION_TICK;
        item_if.now_ms    <= '0;
        item_if.sample_mv <= '0;

        m_last_start = '0;
        m_switch     = 1'b0;
        m_sampling   = 1'b0;
        m_count      = '0;
        m_sum        = '0;
        m_volt       = '0;
        m_pct        = '0;
        cfg_period   = PERIOD_RESET;
        cfg_settle   = SETTLE_RESET;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        verify_regs();

        for (int i = 0; i < DIR_ROWS; i++)
            send_item(dir_rows[i].action, dir_rows[i].now_ms, dir_rows[i].sample_mv,
                      dir_rows[i].typed, dir_rows[i].want);

        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                1: begin np = 16'd1;                     ns = 16'd0;                     end
                2: begin np = 16'd65535;                 ns = 16'd65535;                 end
                3: begin np = 16'($urandom_range(1, 65535)); ns = 16'($urandom_range(65535)); end
                4: begin np = 16'd1;                     ns = 16'd65535;                 end
                default: begin np = 16'd65535;           ns = 16'd0;                     end
            endcase
            if (ph != 0)
                program_regs(np, ns);
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 72; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 72; end
                default: begin send_idle_pct = 6; stall_pct = 6; end
            endcase

            for (n = 0; n < RAND_PER_PHASE; n++)
            begin
                if (n == RAND_PER_PHASE / 2)
                begin
                    item_if.valid <= 1'b0;
                    while (pending_readings.size() != 0)
                        @(posedge clk);
                end
                act = ACTION_TICK;
                t   = $urandom;
                s   = SAMPLE_W'($urandom);
                if (m_sampling)
                begin
                    if (m_count == 0)
                    begin
                        case ($urandom_range(5))
                            0: aim = $urandom_range(4095);
                            1: aim = 1699 + $urandom_range(2);
                            2: aim = 2099 + $urandom_range(2);
                            3: aim = $urandom_range(1700, 2100);
                            4: aim = $urandom_range(1500, 1699);
                            default: aim = $urandom_range(1) ? 4095 : 0;
                        endcase
                    end
                    if ($urandom_range(99) < 88)
                    begin
                        act = ACTION_SAMPLE;
                        v   = aim;
                        if ($urandom_range(1))
                            v = aim + int'($urandom_range(8)) - 4;
                        if (v < 0)
                            v = 0;
                        if (v > 4095)
                            v = 4095;
                        s = SAMPLE_W'(v);
                    end
                end
                else
                begin
                    r    = $urandom_range(99);
                    span = 32'(cfg_period) + 32'(cfg_settle);
                    if (r < 15)
                    begin
                        t = m_last_start + $urandom_range(32'(cfg_period) - 1);
                    end
                    else if (r < 40 && cfg_settle != 0)
                    begin
                        t = m_last_start + 32'(cfg_period) + $urandom_range(32'(cfg_settle) - 1);
                    end
                    else if (r < 85)
                    begin
                        off = ($urandom_range(3) == 0) ? $urandom_range(32'hFFFF_FFFF - span)
                                                       : $urandom_range(3);
                        t = m_last_start + span + off;
                    end
                    else if (r >= 95)
                    begin
                        act = ACTION_SAMPLE;
                    end
                end
                send_item(act, t, s, 1'b0, '0);
            end
        end

        item_if.valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: sim.f
sv/bms_pkg.sv
sv/bms_if.sv
sv/bms_cfg.sv
sv/bms_seq.sv
sv/battery_measure_sequencer.sv
tb/sv/testbench.sv
